FILE: hdl/bus_decoder_with_bank_mapper_unit_macros.svh
// assertion macros for the bus decoder with bank mapper
// expects clk and arst_n in the scope of the module that uses them

`ifndef BUS_DECODER_WITH_BANK_MAPPER_UNIT_MACROS_SVH
`define BUS_DECODER_WITH_BANK_MAPPER_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define BDBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define BDBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/bdbm_pkg.sv
// shared types, codes and reset values for the bus decoder with bank mapper
// no dependencies

package bdbm_pkg;

	// access modes
	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_RAISE = 2'd2,
		MODE_LOWER = 2'd3
	} mode_t;

	// decoded targets
	typedef enum logic [3:0] {
		TGT_ROM      = 4'd0,
		TGT_VRAM     = 4'd1,
		TGT_CRAM     = 4'd2,
		TGT_WRAM     = 4'd3,
		TGT_OAM      = 4'd4,
		TGT_HRAM     = 4'd5,
		TGT_PAD      = 4'd6,
		TGT_TIMER    = 4'd7,
		TGT_VIDEO    = 4'd8,
		TGT_INTERNAL = 4'd9
	} target_t;

	// mapper register regions inside the rom area, address bits 14..13
	typedef enum logic [1:0] {
		MAP_RAM_ENABLE = 2'd0,
		MAP_ROM_BANK   = 2'd1,
		MAP_UPPER_BANK = 2'd2,
		MAP_BANK_MODE  = 2'd3
	} map_region_t;

	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int LINES_W  = 5;
	localparam int TADDR_W  = 21;
	localparam int ROMBANK_W = 7;
	localparam int RAMBANK_W = 2;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	// address map boundaries
	localparam logic [ADDR_W-1:0] VRAM_END  = 16'hA000;
	localparam logic [ADDR_W-1:0] CRAM_END  = 16'hC000;
	localparam logic [ADDR_W-1:0] WRAM_END  = 16'hFE00;
	localparam logic [ADDR_W-1:0] OAM_END   = 16'hFF00;
	localparam logic [ADDR_W-1:0] IE_ADDR   = 16'hFFFF;
	localparam logic [ADDR_W-1:0] IO_TOP    = 16'hFF7F;
	localparam logic [ADDR_W-1:0] VIDEO_LO  = 16'hFF40;
	localparam logic [ADDR_W-1:0] PAD_ADDR  = 16'hFF00;
	localparam logic [ADDR_W-1:0] TIMER_LO  = 16'hFF04;
	localparam logic [ADDR_W-1:0] TIMER_HI  = 16'hFF07;
	localparam logic [ADDR_W-1:0] IF_ADDR   = 16'hFF0F;
	localparam logic [7:0]        OAM_LIMIT = 8'hA0;

	typedef struct packed {
		mode_t               mode;
		logic [ADDR_W-1:0]   address;
		logic [DATA_W-1:0]   write_data;
		logic [LINES_W-1:0]  line_mask;
	} req_word_t;

	typedef struct packed {
		target_t             target;
		logic [TADDR_W-1:0]  target_address;
		logic                write_strobe;
		logic [DATA_W-1:0]   read_data;
		logic [DATA_W-1:0]   flags_now;
		logic [DATA_W-1:0]   enable_now;
	} rsp_word_t;

	// mapper and interrupt state
	typedef struct packed {
		logic [ROMBANK_W-1:0] rom_bank;
		logic [RAMBANK_W-1:0] ram_bank;
		logic                 ram_enabled;
		logic                 banking_mode;
		logic [DATA_W-1:0]    irq_enable;
		logic [DATA_W-1:0]    irq_flags;
		logic [LINES_W-1:0]   irq_lines;
	} state_t;

	localparam state_t STATE_RESET = '{
		rom_bank:     7'd1,
		ram_bank:     2'd0,
		ram_enabled:  1'b0,
		banking_mode: 1'b0,
		irq_enable:   8'd0,
		irq_flags:    8'd0,
		irq_lines:    5'd0
	};

endpackage

FILE: hdl/bdbm_if.sv
// valid/ready channels carrying request and result words
// depends on bdbm_pkg

interface bdbm_req_if;
	logic                  valid;
	logic                  ready;
	bdbm_pkg::req_word_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bdbm_rsp_if;
	logic                  valid;
	logic                  ready;
	bdbm_pkg::rsp_word_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bus_decoder_with_bank_mapper_unit.sv
// top level of the bus decoder with bank mapper
// depends on bdbm_pkg, bdbm_if, bdbm_decode, bdbm_state and the macros header

`include "bus_decoder_with_bank_mapper_unit_macros.svh"

// One bus word enters per cycle while the request side sees ready, and its
// result passes through an input register, the decode and state update, then
// a result register. Sustained rate is one word per clock whenever the result
// side takes words; the rate rests on the read-modify-write of the mapper and
// interrupt registers, done between the two registers. While the result
// register is stalled, a word in the input register waits there and ready to
// the request side drops in that same cycle; an empty input register still
// takes one more word. Every word yields exactly one result.

module bus_decoder_with_bank_mapper_unit (
	input  logic              clk,
	input  logic              arst_n,
	bdbm_req_if.sink          req,
	bdbm_rsp_if.source        rsp
);

	logic                valid_s1;
	bdbm_pkg::req_word_t item_s1;
	logic                valid_s2;
	bdbm_pkg::rsp_word_t res_s2;

	logic                advance;
	bdbm_pkg::rsp_word_t res;
	bdbm_pkg::state_t    cur;
	bdbm_pkg::state_t    nxt;

	// word moves from input to result register
	assign advance   = valid_s1 & (~valid_s2 | rsp.ready);
	assign req.ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	bdbm_decode u_decode (
		.item (item_s1),
		.cur  (cur),
		.res  (res),
		.nxt  (nxt)
	);

	bdbm_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.nxt    (nxt),
		.cur    (cur)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = res_s2;

	// checks on decode and state handling
	`BDBM_ASSERT_NOW(a_rom_bank_nonzero, 1'b1, cur.rom_bank[4:0] != 5'd0, "rom bank low bits zero")
	`BDBM_ASSERT_NOW(a_no_strobe_rom_int, valid_s2 && res_s2.write_strobe, res_s2.target != bdbm_pkg::TGT_ROM && res_s2.target != bdbm_pkg::TGT_INTERNAL, "strobe on rom or internal")
	`BDBM_ASSERT_NEXT(a_state_holds, !advance, $stable(cur), "state changed without a word")
	`BDBM_ASSERT_NEXT(a_raise_sets_lines, advance && item_s1.mode == bdbm_pkg::MODE_RAISE, (cur.irq_lines & $past(item_s1.line_mask)) == $past(item_s1.line_mask), "raised lines not held")

endmodule

FILE: hdl/bdbm_decode.sv
// address decode, bank mapping and next-state logic for one bus access
// depends on bdbm_pkg

module bdbm_decode (
	input  bdbm_pkg::req_word_t item,
	input  bdbm_pkg::state_t    cur,
	output bdbm_pkg::rsp_word_t res,
	output bdbm_pkg::state_t    nxt
);

	logic                         wr;
	logic [bdbm_pkg::ADDR_W-1:0]  a;
	logic [bdbm_pkg::DATA_W-1:0]  v;
	logic [4:0]                   lo_bank;

	assign wr = (item.mode == bdbm_pkg::MODE_WRITE);
	assign a  = item.address;
	assign v  = item.write_data;

	// low rom bank bits never select bank zero
	assign lo_bank = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];

	always_comb begin
		nxt                = cur;
		res.target         = bdbm_pkg::TGT_INTERNAL;
		res.target_address = '0;
		res.write_strobe   = 1'b0;
		res.read_data      = '0;

		unique case (item.mode)
			// interrupt lines: flags set only on a rising edge
			bdbm_pkg::MODE_RAISE: begin
				nxt.irq_flags = cur.irq_flags | {3'b000, item.line_mask & ~cur.irq_lines};
				nxt.irq_lines = cur.irq_lines | item.line_mask;
			end
			bdbm_pkg::MODE_LOWER: begin
				nxt.irq_lines = cur.irq_lines & ~item.line_mask;
			end
			bdbm_pkg::MODE_READ, bdbm_pkg::MODE_WRITE: begin
				priority if (!a[15]) begin
					// rom area, writes go to the mapper
					res.target = bdbm_pkg::TGT_ROM;
					if (a[14]) begin
						res.target_address = {cur.rom_bank, a[13:0]};
					end else begin
						res.target_address = {5'd0, a};
					end
					if (wr) begin
						unique case (bdbm_pkg::map_region_t'(a[14:13]))
							bdbm_pkg::MAP_RAM_ENABLE: begin
								nxt.ram_enabled = (v[3:0] == bdbm_pkg::RAM_ENABLE_KEY);
							end
							bdbm_pkg::MAP_ROM_BANK: begin
								nxt.rom_bank = {cur.rom_bank[6:5], lo_bank};
							end
							bdbm_pkg::MAP_UPPER_BANK: begin
								if (cur.banking_mode) begin
									nxt.ram_bank = v[1:0];
								end else begin
									nxt.ram_bank = '0;
									nxt.rom_bank = {v[1:0], cur.rom_bank[4:0]};
								end
							end
							bdbm_pkg::MAP_BANK_MODE: begin
								nxt.banking_mode = v[0];
								if (v[0]) begin
									nxt.ram_bank = '0;
								end
							end
							default: ;
						endcase
					end
				end else if (a < bdbm_pkg::VRAM_END) begin
					res.target         = bdbm_pkg::TGT_VRAM;
					res.target_address = {8'd0, a[12:0]};
					res.write_strobe   = wr;
				end else if (a < bdbm_pkg::CRAM_END) begin
					// cart ram, banked, writes gated by the enable
					res.target         = bdbm_pkg::TGT_CRAM;
					res.target_address = {6'd0, cur.ram_bank, a[12:0]};
					res.write_strobe   = wr & cur.ram_enabled;
				end else if (a < bdbm_pkg::WRAM_END) begin
					res.target         = bdbm_pkg::TGT_WRAM;
					res.target_address = {8'd0, a[12:0]};
					res.write_strobe   = wr;
				end else if (a < bdbm_pkg::OAM_END) begin
					// oam tail falls through to internal unmapped space
					if (a[7:0] < bdbm_pkg::OAM_LIMIT) begin
						res.target         = bdbm_pkg::TGT_OAM;
						res.target_address = {13'd0, a[7:0]};
						res.write_strobe   = wr;
					end
				end else if (a == bdbm_pkg::IE_ADDR) begin
					if (wr) begin
						nxt.irq_enable = v;
					end else begin
						res.read_data = cur.irq_enable;
					end
				end else if (a > bdbm_pkg::IO_TOP) begin
					res.target         = bdbm_pkg::TGT_HRAM;
					res.target_address = {14'd0, a[6:0]};
					res.write_strobe   = wr;
				end else if (a >= bdbm_pkg::VIDEO_LO) begin
					res.target         = bdbm_pkg::TGT_VIDEO;
					res.target_address = {15'd0, a[5:0]};
					res.write_strobe   = wr;
				end else if (a == bdbm_pkg::PAD_ADDR) begin
					res.target       = bdbm_pkg::TGT_PAD;
					res.write_strobe = wr;
				end else if (a >= bdbm_pkg::TIMER_LO && a <= bdbm_pkg::TIMER_HI) begin
					res.target         = bdbm_pkg::TGT_TIMER;
					res.target_address = {19'd0, a[1:0]};
					res.write_strobe   = wr;
				end else if (a == bdbm_pkg::IF_ADDR) begin
					if (wr) begin
						nxt.irq_flags = v;
					end else begin
						res.read_data = cur.irq_flags;
					end
				end else begin
					// unmapped i/o stays internal with zero read data
				end
			end
			default: ;
		endcase

		res.flags_now  = nxt.irq_flags;
		res.enable_now = nxt.irq_enable;
	end

endmodule

FILE: hdl/bdbm_state.sv
// mapper and interrupt state registers, loaded once per decoded word
// depends on bdbm_pkg

module bdbm_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bdbm_pkg::state_t nxt,
	output bdbm_pkg::state_t cur
);

	bdbm_pkg::state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdbm_pkg::STATE_RESET;
		end else if (load) begin
			state_q <= nxt;
		end
	end

	assign cur = state_q;

endmodule
